[rtl/b2dt_pkg.sv]
// Shared types and constants of the binary to decimal text unit.
package b2dt_pkg;

  localparam int DataW     = 32;
  localparam int DigitN    = 10;
  localparam int CharW     = 6;
  localparam int StageBits = 4;
  localparam int StageN    = DataW / StageBits;
  localparam int IdxW      = $clog2(DigitN);

  localparam logic [CharW-1:0] AsciiZero  = 6'd48;
  localparam logic [CharW-1:0] AsciiMinus = 6'd45;

  typedef struct packed {
    logic                    neg;
    logic [DataW-1:0]        bin;
    logic [DigitN-1:0][3:0]  bcd;
  } b2dt_work_t;

endpackage

[rtl/b2dt_if.sv]
// Stream interfaces: number in, text characters out.
interface b2dt_in_if;
  import b2dt_pkg::*;
  logic             valid;
  logic             ready;
  logic [DataW-1:0] value;
  logic             signed_mode;
  modport source (output valid, value, signed_mode, input ready);
  modport sink   (input valid, value, signed_mode, output ready);
endinterface

interface b2dt_out_if;
  import b2dt_pkg::*;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] text_char;
  logic             last;
  modport source (output valid, text_char, last, input ready);
  modport sink   (input valid, text_char, last, output ready);
endinterface

[rtl/b2dt_dabble_stage.sv]
// One pipeline stage of shift-and-add-3 binary to BCD conversion.
module b2dt_dabble_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  b2dt_pkg::b2dt_work_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output b2dt_pkg::b2dt_work_t out_data
);
  import b2dt_pkg::*;

  b2dt_work_t w;

  always_comb begin
    w = in_data;
    for (int it = 0; it < StageBits; it++) begin
      for (int d = 0; d < DigitN; d++) begin
        if (w.bcd[d] >= 4'd5) begin
          w.bcd[d] = w.bcd[d] + 4'd3;
        end
      end
      {w.bcd, w.bin} = {w.bcd, w.bin} << 1;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= w;
    end
  end

endmodule

[rtl/b2dt_serializer.sv]
// Emits sign and BCD digits one character per word, most significant first.
module b2dt_serializer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  b2dt_pkg::b2dt_work_t        in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [b2dt_pkg::CharW-1:0]  text_char,
  output logic                        last
);
  import b2dt_pkg::*;

  logic                   busy;
  logic                   minus;
  logic [IdxW-1:0]        idx;
  logic [DigitN-1:0][3:0] bcd;
  logic [IdxW-1:0]        top_idx;
  logic                   fire;

  // index of the leading nonzero digit, zero for the value zero
  always_comb begin
    top_idx = '0;
    for (int d = 0; d < DigitN; d++) begin
      if (in_data.bcd[d] != 4'd0) begin
        top_idx = IdxW'(d);
      end
    end
  end

  assign out_valid = busy;
  assign text_char = minus ? AsciiMinus : AsciiZero + {2'b00, bcd[idx]};
  assign last      = !minus && (idx == '0);
  assign fire      = out_valid && out_ready;
  assign in_ready  = !busy || (fire && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_ready) begin
      busy <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      bcd   <= in_data.bcd;
      minus <= in_data.neg;
      idx   <= top_idx;
    end else if (fire) begin
      if (minus) begin
        minus <= 1'b0;
      end else if (idx != '0) begin
        idx <= idx - 1'b1;
      end
    end
  end

endmodule

[rtl/binary_to_decimal_text_unit.sv]
// Top level: 32-bit binary to ASCII decimal text converter.
//
// The number channel takes one word per number: value and signed_mode
// (0 unsigned, 1 two's complement). The text channel returns the decimal
// text one character per word, '-' first for a negative signed value,
// then the digits most significant first with no leading zeros; last
// marks the final character. Zero gives a single '0'.
// A word passes an input register (sign and magnitude), eight
// shift-and-add-3 stages of four bits each, and a character serializer.
// The serializer sends one character per cycle while the receiver is
// ready, so a number takes 1 to 11 characters of the text channel, set
// by its sign and digit count; while it sends, up to nine further
// numbers wait in the pipeline.
// When the receiver stalls, the character on the text channel holds and
// the pipeline fills, then the number channel drops ready; nothing is
// lost or repeated. Synchronous reset empties the pipeline and the
// serializer; no character is pending after reset.
module binary_to_decimal_text_unit (
  input  logic        clk,
  input  logic        rst,
  b2dt_in_if.sink     number,
  b2dt_out_if.source  text
);
  import b2dt_pkg::*;

  logic       front_valid;
  b2dt_work_t front_data;
  logic       front_ready;

  logic       stg_valid [StageN+1];
  logic       stg_ready [StageN+1];
  b2dt_work_t stg_data  [StageN+1];

  logic neg_in;
  assign neg_in = number.signed_mode && number.value[DataW-1];

  assign front_ready  = !front_valid || stg_ready[0];
  assign number.ready = front_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (front_ready) begin
      front_valid <= number.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (front_ready && number.valid) begin
      front_data.neg <= neg_in;
      front_data.bin <= neg_in ? DataW'(32'd0 - number.value) : number.value;
      front_data.bcd <= '0;
    end
  end

  assign stg_valid[0] = front_valid;
  assign stg_data[0]  = front_data;

  for (genvar s = 0; s < StageN; s++) begin : g_stage
    b2dt_dabble_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stg_valid[s]),
      .in_ready  (stg_ready[s]),
      .in_data   (stg_data[s]),
      .out_valid (stg_valid[s+1]),
      .out_ready (stg_ready[s+1]),
      .out_data  (stg_data[s+1])
    );
  end

  b2dt_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stg_valid[StageN]),
    .in_ready  (stg_ready[StageN]),
    .in_data   (stg_data[StageN]),
    .out_valid (text.valid),
    .out_ready (text.ready),
    .text_char (text.text_char),
    .last      (text.last)
  );

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    text.valid |-> (text.text_char == AsciiMinus) ||
                   ((text.text_char >= AsciiZero) && (text.text_char <= AsciiZero + 6'd9)))
    else $error("text character out of range");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    text.valid && (text.text_char == AsciiMinus) |-> !text.last)
    else $error("minus sign flagged as last");

  a_no_lead_zero: assert property (@(posedge clk) disable iff (rst)
    $past(text.valid && text.ready && (text.text_char == AsciiMinus)) && text.valid
    |-> (text.text_char != AsciiZero))
    else $error("leading zero after minus sign");

  a_unsigned_no_sign: assert property (@(posedge clk) disable iff (rst)
    !front_data.neg && front_valid |-> front_data.bcd == '0)
    else $error("front stage digits not cleared");

endmodule

[verif/b2dt_text_checker.sv]
`timescale 1ns / 1ps
// Checker for the binary to decimal text unit: predicts each number's text and compares it.
module b2dt_text_checker (
  input  logic clk,
  input  logic rst,
  b2dt_in_if   number,
  b2dt_out_if  text,
  output int   mismatches,
  output int   outstanding
);
  import b2dt_pkg::*;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
  } text_word_t;

  text_word_t text_q[$];
  int         fail_n = 0;

  function automatic void spell_decimal(input logic [DataW-1:0] v, input logic sm);
    logic             neg;
    logic [DataW-1:0] mag;
    logic [3:0]       dig [DigitN];
    int               nd;
    neg = sm && v[DataW-1];
    mag = neg ? -v : v;
    nd  = 0;
    do begin
      dig[nd] = 4'(mag % 10);
      nd++;
      mag = mag / 10;
    end while (mag != 0 && nd < DigitN);
    if (neg)
      text_q.push_back(text_word_t'{AsciiMinus, 1'b0});
    for (int k = nd - 1; k >= 0; k--)
      text_q.push_back(text_word_t'{AsciiZero + CharW'(dig[k]), k == 0});
  endfunction

  always @(posedge clk) begin
    text_word_t want;
    if (rst) begin
      text_q.delete();
      outstanding <= 0;
      mismatches  <= fail_n;
    end else begin
      if (number.valid && number.ready)
        spell_decimal(number.value, number.signed_mode);
      if (text.valid && text.ready) begin
        if (text_q.size() == 0) begin
          if (fail_n < 10)
            $display("%0t: text word %0d/%0b with nothing expected",
                     $realtime, text.text_char, text.last);
          fail_n++;
        end else begin
          want = text_q.pop_front();
          if (text.text_char !== want.ch || text.last !== want.last) begin
            if (fail_n < 10)
              $display("%0t: text word mismatch: expected char %0d last %0b, got char %0d last %0b",
                       $realtime, want.ch, want.last, text.text_char, text.last);
            fail_n++;
          end
        end
      end
      outstanding <= text_q.size();
      mismatches  <= fail_n;
    end
  end

endmodule

[verif/tb_binary_to_decimal_text_unit.sv]
`timescale 1ns / 1ps
// Testbench top for the binary to decimal text unit: clock, reset, stimulus and verdict.
module tb_binary_to_decimal_text_unit;
  import b2dt_pkg::*;

  localparam int Limit = 200000;

  logic clk;
  logic rst;
  int   cycles = 0;
  int   mismatches;
  int   outstanding;
  int   burst_left = 0;

  b2dt_in_if  number_ch ();
  b2dt_out_if text_ch ();

  binary_to_decimal_text_unit dut (
    .clk    (clk),
    .rst    (rst),
    .number (number_ch),
    .text   (text_ch)
  );

  b2dt_text_checker text_check (
    .clk         (clk),
    .rst         (rst),
    .number      (number_ch),
    .text        (text_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= Limit) begin
      $display("tb_binary_to_decimal_text_unit failed");
      $finish;
    end
  end

  // receiver: cycles through full speed, coin toss, one in four, long stalls
  initial begin
    int ph;
    ph = 0;
    text_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      case ((ph / 97) % 4)
        0:       text_ch.ready <= 1'b1;
        1:       text_ch.ready <= 1'($urandom_range(0, 1));
        2:       text_ch.ready <= (ph % 4 == 0);
        default: text_ch.ready <= (ph % 32 >= 24);
      endcase
      ph++;
    end
  end

  task automatic send_number(input logic [DataW-1:0] v, input logic sm);
    if (burst_left == 0) begin
      number_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    number_ch.valid       <= 1'b1;
    number_ch.value       <= v;
    number_ch.signed_mode <= sm;
    do @(posedge clk); while (!number_ch.ready);
    burst_left--;
  endtask

  initial begin
    longint         span;
    logic [DataW-1:0] v;
    int             kind;
    rst                   = 1'b1;
    number_ch.valid       = 1'b0;
    number_ch.value       = '0;
    number_ch.signed_mode = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_number(32'd0, 1'b0);
    send_number(32'd0, 1'b1);
    send_number(32'd1, 1'b0);
    send_number(32'd9, 1'b1);
    send_number(32'd10, 1'b0);
    send_number(32'd99, 1'b1);
    send_number(32'd100, 1'b0);
    send_number(32'hFFFF_FFFF, 1'b0);
    send_number(32'hFFFF_FFFF, 1'b1);
    send_number(32'h8000_0000, 1'b1);
    send_number(32'h8000_0000, 1'b0);
    send_number(32'h7FFF_FFFF, 1'b0);
    send_number(32'h7FFF_FFFF, 1'b1);
    send_number(32'd999999999, 1'b0);
    send_number(32'd1000000000, 1'b1);
    send_number(-32'd10, 1'b1);
    send_number(-32'd10, 1'b0);
    send_number(-32'd1000000000, 1'b1);
    send_number(-32'd999999999, 1'b1);
    send_number(32'h5555_5555, 1'b0);
    send_number(32'hAAAA_AAAA, 1'b1);

    repeat (100) begin
      kind = $urandom_range(0, 3);
      span = 1;
      repeat ($urandom_range(1, 10)) span *= 10;
      case (kind)
        0:       v = $urandom;
        1:       v = 32'(longint'($urandom) % span);
        2:       v = -32'(longint'($urandom) % span);
        default: v = 32'(span + $urandom_range(0, 2) - 1);
      endcase
      send_number(v, (kind == 2) ? 1'b1 : 1'($urandom_range(0, 1)));
    end
    number_ch.valid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (30) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("tb_binary_to_decimal_text_unit passed");
    else
      $display("tb_binary_to_decimal_text_unit failed");
    $finish;
  end

endmodule
